FILE: hdl/ostc_pkg.sv
// ----------------------------------------------------------------------------
// ostc_pkg
// Shared constants, opcodes and types of the output script template classifier.
// ----------------------------------------------------------------------------
package ostc_pkg;

   localparam int CAPTURE_BYTES_DEFAULT = 120;

   // script opcodes
   localparam logic [7:0] OP_PUSH_LEN1 = 8'h4c;
   localparam logic [7:0] OP_PUSH_LEN2 = 8'h4d;
   localparam logic [7:0] OP_PUSH_LEN4 = 8'h4e;
   localparam logic [7:0] OP_DUP       = 8'h76;
   localparam logic [7:0] OP_KEY_HASH  = 8'ha9;
   localparam logic [7:0] OP_EQ_VERIFY = 8'h88;
   localparam logic [7:0] OP_SIG_CHECK = 8'hac;

   localparam logic [31:0] PK_MIN     = 32'd23;
   localparam logic [31:0] PK_MAX     = 32'd120;
   localparam logic [31:0] HASH_BYTES = 32'd20;
   localparam logic [6:0]  LEN_CAP    = 7'd120;

   typedef enum logic [1:0] {
      ST_PUBKEY      = 2'd0,
      ST_PUBKEY_HASH = 2'd1,
      ST_NONSTANDARD = 2'd2,
      ST_PARSE_ERROR = 2'd3
   } status_type;

   typedef struct packed {
      logic       en;
      logic [6:0] index;
      logic [7:0] data;
   } cap_wr_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      logic [6:0] len;
   } script_end_type;

endpackage

FILE: hdl/ostc_req_if.sv
// ----------------------------------------------------------------------------
// ostc_req_if
// Script byte channel: one optional byte and an end marker per transfer.
// ----------------------------------------------------------------------------
interface ostc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_script;

   modport source (output valid, output data_byte, output has_byte, output end_of_script,
                   input ready);
   modport sink (input valid, input data_byte, input has_byte, input end_of_script,
                 output ready);
endinterface

FILE: hdl/ostc_rsp_if.sv
// ----------------------------------------------------------------------------
// ostc_rsp_if
// Result channel: status and one packed word of the captured key or hash.
// ----------------------------------------------------------------------------
interface ostc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [6:0]  data_length;
   logic [63:0] data_word;
   logic [3:0]  word_bytes;
   logic        last_result;

   modport source (output valid, output status, output data_length, output data_word,
                   output word_bytes, output last_result, input ready);
   modport sink (input valid, input status, input data_length, input data_word,
                 input word_bytes, input last_result, output ready);
endinterface

FILE: hdl/ostc_parser.sv
// ----------------------------------------------------------------------------
// ostc_parser
// Splits script bytes into instructions and tracks both template matches.
// ----------------------------------------------------------------------------
module ostc_parser #(
   parameter int CAPTURE_BYTES = ostc_pkg::CAPTURE_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic [7:0]               data_byte,
   input  logic                     has_byte,
   input  logic                     end_of_script,
   output ostc_pkg::cap_wr_type     cap_wr,
   output ostc_pkg::script_end_type script_end
);
   import ostc_pkg::*;

   typedef enum logic [1:0] {PH_OPCODE, PH_LENGTH, PH_DATA} phase_type;

   localparam logic [9:0] CAP_LIM = 10'(CAPTURE_BYTES);

   phase_type   phase_ff, phase_in;
   logic [2:0]  lenleft_ff, lenleft_in;
   logic [1:0]  lenpos_ff, lenpos_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] dleft_ff, dleft_in;
   logic [2:0]  icount_ff, icount_in;
   logic        pk_ok_ff, pk_ok_in;
   logic        ph_ok_ff, ph_ok_in;
   logic [6:0]  capcnt_ff, capcnt_in;
   logic        capturing_ff, capturing_in;

   logic        bp_ev;
   logic [31:0] bp_len;
   logic        fin_ev;
   logic        fin_push;
   logic [7:0]  fin_op;
   logic [31:0] fin_len;
   logic        pk_match;
   logic        ph_match;
   logic [31:0] acc_new;

   always_comb begin
      phase_in     = phase_ff;
      lenleft_in   = lenleft_ff;
      lenpos_in    = lenpos_ff;
      accum_in     = accum_ff;
      dleft_in     = dleft_ff;
      icount_in    = icount_ff;
      pk_ok_in     = pk_ok_ff;
      ph_ok_in     = ph_ok_ff;
      capcnt_in    = capcnt_ff;
      capturing_in = capturing_ff;
      bp_ev        = 1'b0;
      bp_len       = '0;
      fin_ev       = 1'b0;
      fin_push     = 1'b0;
      fin_op       = '0;
      fin_len      = '0;
      pk_match     = 1'b0;
      ph_match     = 1'b0;
      acc_new      = '0;
      cap_wr       = '0;
      script_end   = '0;

      if (take && has_byte) begin
         unique case (phase_ff)
            PH_OPCODE: begin
               if (data_byte < OP_PUSH_LEN1) begin
                  bp_ev  = 1'b1;
                  bp_len = {24'd0, data_byte};
               end else if (data_byte <= OP_PUSH_LEN4) begin
                  phase_in = PH_LENGTH;
                  if (data_byte == OP_PUSH_LEN1) begin
                     lenleft_in = 3'd1;
                  end else if (data_byte == OP_PUSH_LEN2) begin
                     lenleft_in = 3'd2;
                  end else begin
                     lenleft_in = 3'd4;
                  end
                  lenpos_in = 2'd0;
                  accum_in  = '0;
               end else begin
                  fin_ev = 1'b1;
                  fin_op = data_byte;
               end
            end
            PH_LENGTH: begin
               // little-endian length bytes
               acc_new   = accum_ff | ({24'd0, data_byte} << {lenpos_ff, 3'b000});
               accum_in  = acc_new;
               lenpos_in = lenpos_ff + 2'd1;
               if (lenleft_ff != 3'd0) begin
                  lenleft_in = lenleft_ff - 3'd1;
               end
               if (lenleft_in == 3'd0) begin
                  bp_ev  = 1'b1;
                  bp_len = acc_new;
               end
            end
            PH_DATA: begin
               if (capturing_ff) begin
                  if ({3'b000, capcnt_ff} < CAP_LIM) begin
                     cap_wr.en    = 1'b1;
                     cap_wr.index = capcnt_ff;
                     cap_wr.data  = data_byte;
                  end
                  if (capcnt_ff != 7'd127) begin
                     capcnt_in = capcnt_ff + 7'd1;
                  end
               end
               if (dleft_ff != 32'd0) begin
                  dleft_in = dleft_ff - 32'd1;
               end
               if (dleft_in == 32'd0) begin
                  fin_ev   = 1'b1;
                  fin_push = 1'b1;
                  fin_len  = accum_ff;
               end
            end
            default: begin
               phase_in = PH_OPCODE;
            end
         endcase
      end

      if (bp_ev) begin
         accum_in = bp_len;
         if ((icount_ff == 3'd0 && bp_len >= PK_MIN && bp_len <= PK_MAX) ||
             (icount_ff == 3'd2 && bp_len == HASH_BYTES)) begin
            capturing_in = 1'b1;
            capcnt_in    = '0;
         end
         if (bp_len == 32'd0) begin
            fin_ev   = 1'b1;
            fin_push = 1'b1;
            fin_len  = '0;
         end else begin
            phase_in = PH_DATA;
            dleft_in = bp_len;
         end
      end

      if (fin_ev) begin
         unique case (icount_ff)
            3'd0: begin
               pk_match = fin_push && fin_len >= PK_MIN && fin_len <= PK_MAX;
               ph_match = !fin_push && fin_op == OP_DUP;
            end
            3'd1: begin
               pk_match = !fin_push && fin_op == OP_SIG_CHECK;
               ph_match = !fin_push && fin_op == OP_KEY_HASH;
            end
            3'd2: ph_match = fin_push && fin_len == HASH_BYTES;
            3'd3: ph_match = !fin_push && fin_op == OP_EQ_VERIFY;
            3'd4: ph_match = !fin_push && fin_op == OP_SIG_CHECK;
            default: begin
               pk_match = 1'b0;
               ph_match = 1'b0;
            end
         endcase
         if (!pk_match) pk_ok_in = 1'b0;
         if (!ph_match) ph_ok_in = 1'b0;
         if (icount_ff < 3'd6) icount_in = icount_ff + 3'd1;
         capturing_in = 1'b0;
         phase_in     = PH_OPCODE;
      end

      if (take && end_of_script) begin
         script_end.valid = 1'b1;
         if (phase_in != PH_OPCODE) begin
            script_end.status = ST_PARSE_ERROR;
         end else if (icount_in == 3'd2 && pk_ok_in) begin
            script_end.status = ST_PUBKEY;
         end else if (icount_in == 3'd5 && ph_ok_in) begin
            script_end.status = ST_PUBKEY_HASH;
         end else begin
            script_end.status = ST_NONSTANDARD;
         end
         if (script_end.status == ST_PUBKEY || script_end.status == ST_PUBKEY_HASH) begin
            script_end.len = (capcnt_in > LEN_CAP) ? LEN_CAP : capcnt_in;
         end
         // next transfer starts a fresh script
         phase_in     = PH_OPCODE;
         lenleft_in   = '0;
         lenpos_in    = '0;
         accum_in     = '0;
         dleft_in     = '0;
         icount_in    = '0;
         pk_ok_in     = 1'b1;
         ph_ok_in     = 1'b1;
         capcnt_in    = '0;
         capturing_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         lenleft_ff   <= '0;
         lenpos_ff    <= '0;
         accum_ff     <= '0;
         dleft_ff     <= '0;
         icount_ff    <= '0;
         pk_ok_ff     <= 1'b1;
         ph_ok_ff     <= 1'b1;
         capcnt_ff    <= '0;
         capturing_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         lenleft_ff   <= lenleft_in;
         lenpos_ff    <= lenpos_in;
         accum_ff     <= accum_in;
         dleft_ff     <= dleft_in;
         icount_ff    <= icount_in;
         pk_ok_ff     <= pk_ok_in;
         ph_ok_ff     <= ph_ok_in;
         capcnt_ff    <= capcnt_in;
         capturing_ff <= capturing_in;
      end
   end

endmodule

FILE: hdl/output_script_template_classifier.sv
// ----------------------------------------------------------------------------
// output_script_template_classifier
// Classifies an output script as pay-to-pubkey, pay-to-pubkey-hash,
// nonstandard or malformed and returns the captured key or hash.
//
// req_chan carries one script byte (when has_byte is set) per transfer and
// marks the last transfer of a script with end_of_script. One transfer is
// taken every cycle while req_ready is high. rsp_chan returns, for each
// script, one result per 64-bit word of the captured key or hash (up to 15),
// or one result with zero data for nonstandard scripts and parse errors;
// last_result marks the final one. With the readout idle, rsp_chan.valid
// rises at the clock edge after the one that takes the end transfer, and
// the rest follow one per cycle while rsp_chan is ready, paced by the
// single read port of the capture memory. The memory has two banks, so the
// next script streams in while the previous one is read out; req_ready drops
// only when a second script ends before the first has been fully read out,
// and rises again once that readout finishes. A stalled rsp_chan holds its
// word and stops the readout. Reset clears the parser and the handshakes;
// the capture memory is not cleared and only written bytes are ever reported.
// ----------------------------------------------------------------------------
module output_script_template_classifier #(
   parameter int CAPTURE_BYTES = ostc_pkg::CAPTURE_BYTES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ostc_req_if.sink   req_chan,
   ostc_rsp_if.source rsp_chan
);
   import ostc_pkg::*;

   localparam int         ROWS     = (CAPTURE_BYTES + 7) / 8;
   localparam int         ROW_W    = $clog2(ROWS);
   localparam logic [6:0] ROWS_LIM = 7'(ROWS);
   localparam logic [9:0] CAP_LIM  = 10'(CAPTURE_BYTES);

   typedef struct packed {
      status_type status;
      logic [6:0] len;
      logic [3:0] nwords;
      logic       bank;
   } job_type;

   cap_wr_type     cap_wr;
   script_end_type script_end;
   logic           take;

   logic [7:0][7:0] cap_mem [2][ROWS];

   logic        wbank_ff;
   logic        act_valid_ff, act_valid_in;
   job_type     act_ff, act_in;
   logic [3:0]  act_k_ff, act_k_in;
   logic        pend_valid_ff, pend_valid_in;
   job_type     pend_ff, pend_in;
   job_type     new_job;

   logic            rsp_valid_ff;
   status_type      rsp_status_ff;
   logic [6:0]      rsp_len_ff;
   logic [3:0]      rsp_wbytes_ff;
   logic            rsp_last_ff;
   logic [7:0]      rsp_mask_ff;
   logic [7:0][7:0] rd_word_ff;

   logic             adv;
   logic             issue;
   logic [6:0]       kbase;
   logic [6:0]       remain;
   logic [6:0]       eff_len;
   logic [6:0]       mask_rem;
   logic [3:0]       wbytes;
   logic [3:0]       mcnt;
   logic [7:0]       mask_bits;
   logic             last_word;
   logic [ROW_W-1:0] rd_row;
   logic [7:0]       len_plus;

   assign req_chan.ready = !pend_valid_ff;
   assign take           = req_chan.valid && req_chan.ready;

   ostc_parser #(
      .CAPTURE_BYTES(CAPTURE_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .data_byte    (req_chan.data_byte),
      .has_byte     (req_chan.has_byte),
      .end_of_script(req_chan.end_of_script),
      .cap_wr       (cap_wr),
      .script_end   (script_end)
   );

   always_comb begin
      len_plus       = {1'b0, script_end.len} + 8'd7;
      new_job.status = script_end.status;
      new_job.len    = script_end.len;
      new_job.nwords = (script_end.len == 7'd0) ? 4'd1 : len_plus[6:3];
      new_job.bank   = wbank_ff;
   end

   // readout word selection and byte masks
   always_comb begin
      adv     = !rsp_valid_ff || rsp_chan.ready;
      issue   = act_valid_ff && adv;
      kbase   = {act_k_ff, 3'b000};
      remain  = act_ff.len - kbase;
      eff_len = ({3'b000, act_ff.len} < CAP_LIM) ? act_ff.len : CAP_LIM[6:0];
      if (act_ff.len == 7'd0) begin
         wbytes = 4'd0;
      end else if (remain > 7'd8) begin
         wbytes = 4'd8;
      end else begin
         wbytes = remain[3:0];
      end
      // bytes past the end of the store read as zero
      mask_rem = eff_len - kbase;
      if (eff_len <= kbase) begin
         mcnt = 4'd0;
      end else if (mask_rem > 7'd8) begin
         mcnt = 4'd8;
      end else begin
         mcnt = mask_rem[3:0];
      end
      for (int i = 0; i < 8; i++) begin
         mask_bits[i] = 4'(i) < mcnt;
      end
      last_word = act_k_ff == (act_ff.nwords - 4'd1);
      rd_row    = ({3'b000, act_k_ff} < ROWS_LIM) ? ROW_W'(act_k_ff) : '0;
   end

   // readout slot and one waiting script
   always_comb begin
      act_valid_in  = act_valid_ff;
      act_in        = act_ff;
      act_k_in      = act_k_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (issue) begin
         if (last_word) begin
            act_valid_in  = pend_valid_ff;
            act_in        = pend_ff;
            act_k_in      = '0;
            pend_valid_in = 1'b0;
         end else begin
            act_k_in = act_k_ff + 4'd1;
         end
      end
      // an ending script goes straight to readout when the slot frees up
      if (script_end.valid) begin
         if (!act_valid_in) begin
            act_valid_in = 1'b1;
            act_in       = new_job;
            act_k_in     = '0;
         end else begin
            pend_valid_in = 1'b1;
            pend_in       = new_job;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cap_wr.en) begin
         cap_mem[wbank_ff][ROW_W'(cap_wr.index >> 3)][cap_wr.index[2:0]] <= cap_wr.data;
      end
      if (issue) begin
         rd_word_ff <= cap_mem[act_ff.bank][rd_row];
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      act_k_ff <= act_k_in;
      pend_ff  <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wbank_ff      <= 1'b0;
         act_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (adv) begin
            rsp_valid_ff <= act_valid_ff;
         end
         if (issue) begin
            rsp_status_ff <= act_ff.status;
            rsp_len_ff    <= act_ff.len;
            rsp_wbytes_ff <= wbytes;
            rsp_last_ff   <= last_word;
            rsp_mask_ff   <= mask_bits;
         end
         act_valid_ff  <= act_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (script_end.valid) begin
            wbank_ff <= !wbank_ff;
         end
      end
   end

   always_comb begin
      rsp_chan.valid       = rsp_valid_ff;
      rsp_chan.status      = rsp_status_ff;
      rsp_chan.data_length = rsp_len_ff;
      rsp_chan.word_bytes  = rsp_wbytes_ff;
      rsp_chan.last_result = rsp_last_ff;
      for (int i = 0; i < 8; i++) begin
         rsp_chan.data_word[8*i +: 8] = rd_word_ff[i] & {8{rsp_mask_ff[i]}};
      end
   end

endmodule
